FILE: hdl/sscu_pkg.sv
// Shared types and constants for the sampled-counter heavy-hitter table.
`timescale 1ns / 1ps
`default_nettype none
package sscu_pkg;

	localparam int FP_W          = 32;
	localparam int CNT_W         = 16;
	localparam int SCALE_W       = 6;
	localparam int EST_W         = 63;
	localparam int SLOT_W        = 6;
	localparam int DEF_ENTRIES   = 64;
	localparam int DEF_MAX_SCALE = 47;

	localparam logic [CNT_W-1:0] COUNT_TOP = {CNT_W{1'b1}};

	localparam logic KIND_INC   = 1'b0;
	localparam logic KIND_QUERY = 1'b1;

	// Control of the shared compare unit for one slot read back from the table.
	typedef struct packed {
		logic step;
		logic first;
	} scan_ctrl_t;

endpackage
`default_nettype wire

FILE: hdl/sscu_ifs.sv
// Valid/ready channel interfaces for request and result beats.
`timescale 1ns / 1ps
`default_nettype none
interface sscu_item_if
	import sscu_pkg::*;
	;
	logic            valid;
	logic            ready;
	logic            kind;
	logic [FP_W-1:0] key_fingerprint;
	logic            sample_hit;

	modport source (output valid, kind, key_fingerprint, sample_hit, input ready);
	modport sink   (input valid, kind, key_fingerprint, sample_hit, output ready);
endinterface

interface sscu_result_if
	import sscu_pkg::*;
	;
	logic              valid;
	logic              ready;
	logic [EST_W-1:0]  estimate;
	logic [SLOT_W-1:0] slot;
	logic              was_tracked;

	modport source (output valid, estimate, slot, was_tracked, input ready);
	modport sink   (input valid, estimate, slot, was_tracked, output ready);
endinterface
`default_nettype wire

FILE: hdl/sscu_ram.sv
// Simple dual-port RAM: one write port, one registered read port.
`timescale 1ns / 1ps
`default_nettype none
module sscu_ram
	import sscu_pkg::*;
#(
	parameter int WIDTH = CNT_W,
	parameter int DEPTH = DEF_ENTRIES,
	localparam int AW   = $clog2(DEPTH)
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic             re,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule
`default_nettype wire

FILE: hdl/sscu_scan.sv
// Shared compare unit: first fingerprint match and lowest-index minimum count.
`timescale 1ns / 1ps
`default_nettype none
module sscu_scan
	import sscu_pkg::*;
#(
	parameter int ENTRIES = DEF_ENTRIES,
	localparam int IDX_W  = $clog2(ENTRIES)
) (
	input  wire logic             clk,
	input  wire scan_ctrl_t       ctrl,
	input  wire logic [IDX_W-1:0] idx,
	input  wire logic [FP_W-1:0]  fp,
	input  wire logic [FP_W-1:0]  key,
	input  wire logic [CNT_W-1:0] count,
	output logic                  match_q,
	output logic      [IDX_W-1:0] match_idx_q,
	output logic      [CNT_W-1:0] match_cnt_q,
	output logic      [IDX_W-1:0] min_idx_q,
	output logic      [CNT_W-1:0] min_cnt_q
);

	logic hit;
	logic found;

	assign hit   = (key == fp);
	assign found = ctrl.first ? 1'b0 : match_q;

	always_ff @(posedge clk) begin
		if (ctrl.step) begin
			// Keep the earliest match only.
			if (!found && hit) begin
				match_idx_q <= idx;
				match_cnt_q <= count;
			end
			match_q <= found | hit;
			// Strict less-than keeps the lowest index among equal minima.
			if (ctrl.first || count < min_cnt_q) begin
				min_idx_q <= idx;
				min_cnt_q <= count;
			end
		end
	end

endmodule
`default_nettype wire

FILE: hdl/space_saving_sampled_counters_unit.sv
// Top level: Space-Saving heavy-hitter table with sampled 16-bit counters.
//
// Usage: requests arrive as beats on the item channel (kind, key_fingerprint,
// sample_hit) and each produces exactly one beat on the result channel
// (estimate, slot, was_tracked). Both channels use valid/ready handshakes.
// The table sits in two on-chip RAMs (fingerprints and counters) that are
// read one slot per cycle by a single compare unit under a small sequencer.
// An increment goes from acceptance through the scan, decide, write and
// result steps to the result beat; a query skips the write step. The
// linear scan walks every slot of the counter and fingerprint RAMs.
// When a counter would overflow below MAX_SCALE, a halving pass walks the
// counter RAM once more. The block takes one request at a time and
// deasserts item.ready until it has finished it.
// After reset the sequencer clears both RAMs, one slot per cycle, and
// item.ready stays low meanwhile. The scale resets to zero. The result is
// held in an output register; if the receiver stalls, a new request is
// still taken and scanned, and only its result waits until the register
// has been emptied.
`timescale 1ns / 1ps
`default_nettype none
module space_saving_sampled_counters_unit
	import sscu_pkg::*;
#(
	parameter int ENTRIES   = DEF_ENTRIES,
	parameter int MAX_SCALE = DEF_MAX_SCALE
) (
	input wire logic      clk,
	input wire logic      arst_n,
	sscu_item_if.sink     item,
	sscu_result_if.source result
);

	localparam int IDX_W = $clog2(ENTRIES);
	localparam logic [IDX_W-1:0] LAST = IDX_W'(ENTRIES - 1);
	localparam logic [CNT_W-1:0] HALF_TOP_INC = CNT_W'((COUNT_TOP >> 1) + 1);

	localparam logic [2:0] ST_CLEAR  = 3'd0;
	localparam logic [2:0] ST_IDLE   = 3'd1;
	localparam logic [2:0] ST_SCAN   = 3'd2;
	localparam logic [2:0] ST_DECIDE = 3'd3;
	localparam logic [2:0] ST_HALVE  = 3'd4;
	localparam logic [2:0] ST_WRITE  = 3'd5;
	localparam logic [2:0] ST_RESULT = 3'd6;

	logic [2:0]         state_q;
	logic [IDX_W-1:0]   addr_q;
	logic               issue_q;
	logic               rdv_q;
	logic [IDX_W-1:0]   rdi_q;
	logic [SCALE_W-1:0] scale_q;

	// Captured request.
	logic               kind_q;
	logic [FP_W-1:0]    fp_q;
	logic               hit_q;

	// Chosen slot and its new count.
	logic [IDX_W-1:0]   idx_q;
	logic [CNT_W-1:0]   cnt_q;
	logic               tracked_q;
	logic               upd_cnt_q;
	logic               upd_key_q;

	// Output register.
	logic               out_valid_q;
	logic [EST_W-1:0]   est_q;
	logic [SLOT_W-1:0]  slot_q;
	logic               trk_q;

	logic [CNT_W-1:0]   rd_cnt;
	logic [FP_W-1:0]    rd_key;
	logic               cnt_we;
	logic [IDX_W-1:0]   cnt_waddr;
	logic [CNT_W-1:0]   cnt_wdata;
	logic               key_we;
	logic [IDX_W-1:0]   key_waddr;
	logic [FP_W-1:0]    key_wdata;

	scan_ctrl_t         sc_ctrl;
	logic               sc_match;
	logic [IDX_W-1:0]   sc_match_idx;
	logic [CNT_W-1:0]   sc_match_cnt;
	logic [IDX_W-1:0]   sc_min_idx;
	logic [CNT_W-1:0]   sc_min_cnt;

	logic               accept;
	logic               out_free;
	logic               last_rd;
	logic [IDX_W-1:0]   pick_idx;
	logic [CNT_W-1:0]   pick_cnt;
	logic               do_inc;

	assign item.ready  = (state_q == ST_IDLE);
	assign accept      = item.valid && item.ready;
	assign out_free    = !out_valid_q || result.ready;
	assign last_rd     = rdv_q && (rdi_q == LAST);

	assign result.valid       = out_valid_q;
	assign result.estimate    = est_q;
	assign result.slot        = slot_q;
	assign result.was_tracked = trk_q;

	// A matched fingerprint wins; otherwise the minimum counter is taken.
	assign pick_idx = sc_match ? sc_match_idx : sc_min_idx;
	assign pick_cnt = sc_match ? sc_match_cnt : sc_min_cnt;
	// At scale zero every increment counts; otherwise only sampled ones.
	assign do_inc   = (scale_q == '0) || hit_q;

	assign sc_ctrl.step  = (state_q == ST_SCAN) && rdv_q;
	assign sc_ctrl.first = (rdi_q == '0);

	// Write port selection for both RAMs.
	always_comb begin
		cnt_we    = 1'b0;
		cnt_waddr = addr_q;
		cnt_wdata = '0;
		key_we    = 1'b0;
		key_waddr = addr_q;
		key_wdata = '0;
		case (state_q)
			ST_CLEAR: begin
				cnt_we = 1'b1;
				key_we = 1'b1;
			end
			ST_HALVE: begin
				cnt_we    = rdv_q;
				cnt_waddr = rdi_q;
				cnt_wdata = rd_cnt >> 1;
			end
			ST_WRITE: begin
				cnt_we    = upd_cnt_q;
				cnt_waddr = idx_q;
				cnt_wdata = cnt_q;
				key_we    = upd_key_q;
				key_waddr = idx_q;
				key_wdata = fp_q;
			end
			default: begin
			end
		endcase
	end

	sscu_ram #(
		.WIDTH (CNT_W),
		.DEPTH (ENTRIES)
	) u_cnt_ram (
		.clk   (clk),
		.we    (cnt_we),
		.waddr (cnt_waddr),
		.wdata (cnt_wdata),
		.re    (issue_q),
		.raddr (addr_q),
		.rdata (rd_cnt)
	);

	sscu_ram #(
		.WIDTH (FP_W),
		.DEPTH (ENTRIES)
	) u_key_ram (
		.clk   (clk),
		.we    (key_we),
		.waddr (key_waddr),
		.wdata (key_wdata),
		.re    (issue_q),
		.raddr (addr_q),
		.rdata (rd_key)
	);

	sscu_scan #(
		.ENTRIES (ENTRIES)
	) u_scan (
		.clk         (clk),
		.ctrl        (sc_ctrl),
		.idx         (rdi_q),
		.fp          (fp_q),
		.key         (rd_key),
		.count       (rd_cnt),
		.match_q     (sc_match),
		.match_idx_q (sc_match_idx),
		.match_cnt_q (sc_match_cnt),
		.min_idx_q   (sc_min_idx),
		.min_cnt_q   (sc_min_cnt)
	);

	// Sequencer and control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			addr_q      <= '0;
			issue_q     <= 1'b0;
			rdv_q       <= 1'b0;
			rdi_q       <= '0;
			scale_q     <= '0;
			upd_cnt_q   <= 1'b0;
			upd_key_q   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			// Read-valid and read-index registers aligned with the registered RAM read.
			rdv_q <= issue_q;
			rdi_q <= addr_q;
			if (issue_q) begin
				addr_q <= addr_q + 1'b1;
				if (addr_q == LAST) begin
					issue_q <= 1'b0;
				end
			end

			// The output register loads a new beat or empties once taken.
			if (state_q == ST_RESULT && out_free) begin
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end

			case (state_q)
				ST_CLEAR: begin
					if (addr_q == LAST) begin
						addr_q  <= '0;
						state_q <= ST_IDLE;
					end else begin
						addr_q <= addr_q + 1'b1;
					end
				end
				ST_IDLE: begin
					if (accept) begin
						addr_q  <= '0;
						issue_q <= 1'b1;
						state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (last_rd) begin
						state_q <= ST_DECIDE;
					end
				end
				ST_DECIDE: begin
					upd_key_q <= (kind_q == KIND_INC) && !sc_match;
					if (kind_q == KIND_QUERY) begin
						upd_cnt_q <= 1'b0;
						state_q   <= ST_RESULT;
					end else if (do_inc && pick_cnt != COUNT_TOP) begin
						upd_cnt_q <= 1'b1;
						state_q   <= ST_WRITE;
					end else if (do_inc && scale_q < SCALE_W'(MAX_SCALE)) begin
						// Overflow: raise the scale and halve the whole table.
						upd_cnt_q <= 1'b1;
						scale_q   <= scale_q + 1'b1;
						addr_q    <= '0;
						issue_q   <= 1'b1;
						state_q   <= ST_HALVE;
					end else begin
						upd_cnt_q <= 1'b0;
						state_q   <= ST_WRITE;
					end
				end
				ST_HALVE: begin
					if (last_rd) begin
						state_q <= ST_WRITE;
					end
				end
				ST_WRITE: begin
					state_q <= ST_RESULT;
				end
				ST_RESULT: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (accept) begin
			kind_q <= item.kind;
			fp_q   <= item.key_fingerprint;
			hit_q  <= item.sample_hit;
		end
		if (state_q == ST_DECIDE) begin
			idx_q     <= pick_idx;
			tracked_q <= sc_match;
			if (kind_q == KIND_INC && do_inc && pick_cnt != COUNT_TOP) begin
				cnt_q <= pick_cnt + 1'b1;
			end else if (kind_q == KIND_INC && do_inc
				     && scale_q < SCALE_W'(MAX_SCALE)) begin
				cnt_q <= HALF_TOP_INC;
			end else begin
				cnt_q <= pick_cnt;
			end
		end
		if (state_q == ST_RESULT && out_free) begin
			est_q  <= EST_W'(cnt_q) << scale_q;
			slot_q <= SLOT_W'(idx_q);
			trk_q  <= tracked_q;
		end
	end

	// The scale never passes its ceiling.
	a_scale_cap: assert property (@(posedge clk) disable iff (!arst_n)
		scale_q <= SCALE_W'(MAX_SCALE))
		else $error("scale exceeded its ceiling");

	// A result beat only appears after the result step of the sequencer.
	a_result_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == ST_RESULT))
		else $error("result raised outside the result step");

	// Once a request is taken the block is busy on the next cycle.
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> !item.ready)
		else $error("request accepted while a scan is running");

	// A halving pass only runs with a raised scale.
	a_halve_scale: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_HALVE) |-> (scale_q != '0))
		else $error("halving pass at scale zero");

endmodule
`default_nettype wire
